FILE: rtl/core/drm_pkg.sv
// ----------------------------------------------------------------------------
// Day-range merge table package
// Field widths, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package drm_pkg;

    localparam int CMD_W       = 2;
    localparam int DAY_FIELD_W = 16;
    localparam int INDEX_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_DONE
    } drm_state_t;

endpackage

FILE: rtl/core/drm_channel_if.sv
// ----------------------------------------------------------------------------
// Day-range merge table channels
// Request and response channels with valid, ready and payload.
// ----------------------------------------------------------------------------
interface drm_req_if;
    logic                            valid;
    logic                            ready;
    logic [drm_pkg::CMD_W-1:0]       cmd;
    logic                            pool;
    logic [drm_pkg::DAY_FIELD_W-1:0] start_day;
    logic [drm_pkg::DAY_FIELD_W-1:0] end_day;
    logic [drm_pkg::INDEX_W-1:0]     entry_index;

    modport source (output valid, cmd, pool, start_day, end_day, entry_index, input ready);
    modport sink (input valid, cmd, pool, start_day, end_day, entry_index, output ready);
endinterface

interface drm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [drm_pkg::STATUS_W-1:0]    status;
    logic                            hit;
    logic [drm_pkg::DAY_FIELD_W-1:0] range_start;
    logic [drm_pkg::DAY_FIELD_W-1:0] range_end;
    logic [drm_pkg::COUNT_W-1:0]     entry_count;

    modport source (output valid, status, hit, range_start, range_end, entry_count, input ready);
    modport sink (input valid, status, hit, range_start, range_end, entry_count, output ready);
endinterface

FILE: rtl/core/day_range_merge_table_core.sv
// ----------------------------------------------------------------------------
// Day-range merge table core
// Two tables of day ranges with merge-insert, containment query, read, clear.
// ----------------------------------------------------------------------------
// A request transfer carries a command, a table select, a day range and an
// entry index; every request yields exactly one response transfer with a
// status, a hit flag, the range read and the table's entry count.
// The block takes one request at a time and is not ready while it works.
// Insert and query walk the selected table one entry a cycle through a
// single compare unit fed by the registered read port of the entry memory,
// and stop early at the first entry that matches.
// A read passes through a fetch state before its response is built; a clear
// or an out-of-range read goes straight to the done state.
// The block is ready again in the same cycle that the response is offered.
// The response sits in an output register, so a stalled receiver holds only
// that register; the next request is taken while the response waits, and
// its result is held back until the output register is free.
// Reset clears both entry counts and the control state; the entry memory
// is not cleared, since only entries below a count are ever read.
// ----------------------------------------------------------------------------
module day_range_merge_table_core #(
    parameter int ENTRIES  = 16,
    parameter int DAY_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    drm_req_if.sink    req,
    drm_rsp_if.source  rsp
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int EXT_W  = (DAY_BITS > drm_pkg::DAY_FIELD_W) ? DAY_BITS : drm_pkg::DAY_FIELD_W;
    localparam int CMP_W  = (CNT_W > drm_pkg::INDEX_W) ? CNT_W : drm_pkg::INDEX_W;
    localparam int IE_W   = (IDX_W > drm_pkg::INDEX_W) ? IDX_W : drm_pkg::INDEX_W;
    localparam int OC_W   = (CNT_W > drm_pkg::COUNT_W) ? CNT_W : drm_pkg::COUNT_W;

    drm_pkg::drm_state_t state_reg, state_next;

    logic [drm_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic                      pool_reg, pool_next;
    logic [DAY_BITS-1:0]       s_reg, s_next;
    logic [DAY_BITS-1:0]       e_reg, e_next;
    logic [CNT_W-1:0]          cnt_reg [2];
    logic [CNT_W-1:0]          cnt_next [2];
    logic [CNT_W-1:0]          scan_reg, scan_next;
    logic                      pend_reg, pend_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;

    logic [drm_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                         res_hit_reg, res_hit_next;
    logic [DAY_BITS-1:0]          res_start_reg, res_start_next;
    logic [DAY_BITS-1:0]          res_end_reg, res_end_next;

    logic                            out_valid_reg, out_valid_next;
    logic [drm_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic                            out_hit_reg, out_hit_next;
    logic [drm_pkg::DAY_FIELD_W-1:0] out_start_reg, out_start_next;
    logic [drm_pkg::DAY_FIELD_W-1:0] out_end_reg, out_end_next;
    logic [drm_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DAY_BITS-1:0] mem_wstart;
    logic [DAY_BITS-1:0] mem_wend;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [DAY_BITS-1:0] rd_start;
    logic [DAY_BITS-1:0] rd_end;

    logic                match;
    logic [DAY_BITS-1:0] mrg_start;
    logic [DAY_BITS-1:0] mrg_end;
    logic                merge_mode;

    logic                accept;
    logic                out_free;
    logic [CNT_W-1:0]    cur_cnt;
    logic                issue;
    logic                scan_hit;
    logic                scan_miss;
    logic [EXT_W-1:0]    in_s_ext;
    logic [EXT_W-1:0]    in_e_ext;
    logic [DAY_BITS-1:0] in_s;
    logic [DAY_BITS-1:0] in_e;
    logic [CMP_W-1:0]    idx_cmp;
    logic [CMP_W-1:0]    sel_cnt_cmp;
    logic                idx_bad;
    logic [IE_W-1:0]     idx_ext;
    logic [IDX_W-1:0]    idx_addr;
    logic [EXT_W-1:0]    rs_ext;
    logic [EXT_W-1:0]    re_ext;
    logic [OC_W-1:0]     cnt_ext;

    assign req.ready = (state_reg == drm_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign cur_cnt   = cnt_reg[pool_reg];
    assign issue     = (scan_reg < cur_cnt);
    assign scan_hit  = pend_reg && match;
    assign scan_miss = !pend_reg && !issue;

    assign in_s_ext    = EXT_W'(req.start_day);
    assign in_e_ext    = EXT_W'(req.end_day);
    assign in_s        = in_s_ext[DAY_BITS-1:0];
    assign in_e        = in_e_ext[DAY_BITS-1:0];
    assign idx_cmp     = CMP_W'(req.entry_index);
    assign sel_cnt_cmp = CMP_W'(cnt_reg[req.pool]);
    assign idx_bad     = (idx_cmp >= sel_cnt_cmp);
    assign idx_ext     = IE_W'(req.entry_index);
    assign idx_addr    = idx_ext[IDX_W-1:0];

    assign rs_ext  = EXT_W'(res_start_reg);
    assign re_ext  = EXT_W'(res_end_reg);
    assign cnt_ext = OC_W'(cur_cnt);

    assign merge_mode = (cmd_reg == drm_pkg::CMD_INSERT);

    drm_store #(
        .ADDR_W   (ADDR_W),
        .DAY_BITS (DAY_BITS)
    ) u_store (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wstart (mem_wstart),
        .wend   (mem_wend),
        .re     (mem_re),
        .raddr  (mem_raddr),
        .rstart (rd_start),
        .rend   (rd_end)
    );

    drm_cmp #(
        .DAY_BITS (DAY_BITS)
    ) u_cmp (
        .merge_mode (merge_mode),
        .s          (s_reg),
        .e          (e_reg),
        .es         (rd_start),
        .ee         (rd_end),
        .match      (match),
        .new_start  (mrg_start),
        .new_end    (mrg_end)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd)
                        drm_pkg::CMD_INSERT, drm_pkg::CMD_QUERY:
                        begin
                            state_next = drm_pkg::ST_SCAN;
                        end
                        drm_pkg::CMD_READ:
                        begin
                            state_next = idx_bad ? drm_pkg::ST_DONE : drm_pkg::ST_FETCH;
                        end
                        default:
                        begin
                            state_next = drm_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            drm_pkg::ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    state_next = drm_pkg::ST_DONE;
                end
            end
            drm_pkg::ST_FETCH:
            begin
                state_next = drm_pkg::ST_DONE;
            end
            drm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = drm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = drm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        pool_next       = pool_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        cnt_next[0]     = cnt_reg[0];
        cnt_next[1]     = cnt_reg[1];
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_start_next  = res_start_reg;
        res_end_next    = res_end_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_hit_next    = out_hit_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wstart      = '0;
        mem_wend        = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            drm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = req.cmd;
                    pool_next       = req.pool;
                    s_next          = in_s;
                    e_next          = in_e;
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    res_status_next = drm_pkg::STATUS_DONE;
                    res_hit_next    = 1'b0;
                    res_start_next  = '0;
                    res_end_next    = '0;
                    case (req.cmd)
                        drm_pkg::CMD_READ:
                        begin
                            if (idx_bad)
                            begin
                                res_status_next = drm_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = {req.pool, idx_addr};
                            end
                        end
                        drm_pkg::CMD_CLEAR:
                        begin
                            cnt_next[0] = '0;
                            cnt_next[1] = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            drm_pkg::ST_SCAN:
            begin
                pend_next     = issue;
                pend_idx_next = scan_reg[IDX_W-1:0];
                if (issue)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {pool_reg, scan_reg[IDX_W-1:0]};
                    scan_next = scan_reg + CNT_W'(1);
                end
                if (scan_hit)
                begin
                    res_hit_next = 1'b1;
                    pend_next    = 1'b0;
                    if (merge_mode)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = {pool_reg, pend_idx_reg};
                        mem_wstart = mrg_start;
                        mem_wend   = mrg_end;
                    end
                end
                else if (scan_miss && merge_mode)
                begin
                    if (cur_cnt >= CNT_W'(ENTRIES))
                    begin
                        res_status_next = drm_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        mem_we             = 1'b1;
                        mem_waddr          = {pool_reg, cur_cnt[IDX_W-1:0]};
                        mem_wstart         = s_reg;
                        mem_wend           = e_reg;
                        cnt_next[pool_reg] = cur_cnt + CNT_W'(1);
                    end
                end
            end
            drm_pkg::ST_FETCH:
            begin
                res_start_next = rd_start;
                res_end_next   = rd_end;
            end
            drm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_hit_next    = res_hit_reg;
                    out_start_next  = rs_ext[drm_pkg::DAY_FIELD_W-1:0];
                    out_end_next    = re_ext[drm_pkg::DAY_FIELD_W-1:0];
                    out_count_next  = cnt_ext[drm_pkg::COUNT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drm_pkg::ST_IDLE;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg[0]    <= cnt_next[0];
            cnt_reg[1]    <= cnt_next[1];
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pool_reg       <= pool_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        scan_reg       <= scan_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        res_start_reg  <= res_start_next;
        res_end_reg    <= res_end_next;
        out_status_reg <= out_status_next;
        out_hit_reg    <= out_hit_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.range_start = out_start_reg;
    assign rsp.range_end   = out_end_reg;
    assign rsp.entry_count = out_count_reg;

endmodule

FILE: rtl/core/drm_store.sv
// ----------------------------------------------------------------------------
// Day-range merge table entry store
// Range memory for both tables, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module drm_store #(
    parameter int ADDR_W   = 5,
    parameter int DAY_BITS = 16
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  logic [DAY_BITS-1:0] wstart,
    input  logic [DAY_BITS-1:0] wend,
    input  logic                re,
    input  logic [ADDR_W-1:0]   raddr,
    output logic [DAY_BITS-1:0] rstart,
    output logic [DAY_BITS-1:0] rend
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [2*DAY_BITS-1:0] mem [DEPTH];
    logic [2*DAY_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wstart, wend};
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rstart = rdata_reg[2*DAY_BITS-1:DAY_BITS];
    assign rend   = rdata_reg[DAY_BITS-1:0];

endmodule

FILE: rtl/core/drm_cmp.sv
// ----------------------------------------------------------------------------
// Day-range merge table compare unit
// Shared merge or containment test of one stored entry against the range.
// ----------------------------------------------------------------------------
module drm_cmp #(
    parameter int DAY_BITS = 16
) (
    input  logic                merge_mode,
    input  logic [DAY_BITS-1:0] s,
    input  logic [DAY_BITS-1:0] e,
    input  logic [DAY_BITS-1:0] es,
    input  logic [DAY_BITS-1:0] ee,
    output logic                match,
    output logic [DAY_BITS-1:0] new_start,
    output logic [DAY_BITS-1:0] new_end
);

    logic [DAY_BITS:0] ee_inc;
    logic [DAY_BITS:0] e_inc;
    logic              apart;
    logic              covered;

    // The touch test is done one bit wider so that a day at the top of the
    // range still counts as adjacent.
    assign ee_inc  = {1'b0, ee} + {{DAY_BITS{1'b0}}, 1'b1};
    assign e_inc   = {1'b0, e} + {{DAY_BITS{1'b0}}, 1'b1};
    assign apart   = ({1'b0, s} > ee_inc) || (e_inc < {1'b0, es});
    assign covered = (s >= es) && (e <= ee);

    assign match     = merge_mode ? !apart : covered;
    assign new_start = (s < es) ? s : es;
    assign new_end   = (e > ee) ? e : ee;

endmodule

FILE: rtl/core/drm_checker.sv
// ----------------------------------------------------------------------------
// Day-range merge table port checker
// Assertions on the request and response ports of the core, bound to it.
// ----------------------------------------------------------------------------
module drm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [drm_pkg::STATUS_W-1:0]    status,
    input logic                            hit,
    input logic [drm_pkg::DAY_FIELD_W-1:0] range_start,
    input logic [drm_pkg::DAY_FIELD_W-1:0] range_end,
    input logic [drm_pkg::COUNT_W-1:0]     entry_count
);

    // A request transfer occupies the block for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while the previous one is still in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(hit)
            && $stable(range_start) && $stable(range_end) && $stable(entry_count)))
        else $error("stalled response changed or was dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == drm_pkg::STATUS_RANGE))
            |-> (!hit && (range_start == '0) && (range_end == '0)))
        else $error("out-of-range read returned data or a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == drm_pkg::STATUS_FULL))
            |-> (!hit && (range_start == '0) && (range_end == '0)))
        else $error("full-table insert reported a hit or range data");

endmodule

bind day_range_merge_table_core drm_checker u_drm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .hit         (rsp.hit),
    .range_start (rsp.range_start),
    .range_end   (rsp.range_end),
    .entry_count (rsp.entry_count)
);
